### src/toy_cpu_execute_unit_assert.svh
// assertion macros for the toy cpu execute unit
`ifndef TOY_CPU_EXECUTE_UNIT_ASSERT_SVH
`define TOY_CPU_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TCPU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TCPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tcpu_pkg.sv
// shared types, constants and codes of the toy cpu execute unit
`timescale 1ns / 1ps
`default_nettype none
package tcpu_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);
  localparam int unsigned RF_DEPTH  = 32;
  localparam int unsigned RF_AW     = $clog2(RF_DEPTH);
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_SUB = 5'd1;
  localparam logic [4:0] OP_MUL = 5'd2;
  localparam logic [4:0] OP_DIV = 5'd3;
  localparam logic [4:0] OP_AND = 5'd4;
  localparam logic [4:0] OP_OR  = 5'd5;
  localparam logic [4:0] OP_XOR = 5'd6;
  localparam logic [4:0] OP_SHL = 5'd7;
  localparam logic [4:0] OP_LDB = 5'd10;
  localparam logic [4:0] OP_LDW = 5'd11;
  localparam logic [4:0] OP_STB = 5'd12;
  localparam logic [4:0] OP_STW = 5'd13;
  localparam logic [4:0] OP_JMP = 5'd20;
  localparam logic [4:0] OP_JZS = 5'd21;
  localparam logic [4:0] OP_JZC = 5'd22;
  localparam logic [4:0] OP_JCS = 5'd23;
  localparam logic [4:0] OP_JCC = 5'd24;
  localparam logic [4:0] OP_JNS = 5'd25;
  localparam logic [4:0] OP_JNC = 5'd26;
  localparam logic [4:0] OP_IN  = 5'd27;
  localparam logic [4:0] OP_OUT = 5'd28;
  localparam logic [4:0] OP_HLT = 5'd31;

  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_HALT = 3'd1;
  localparam logic [2:0] ST_DIVZ = 3'd2;
  localparam logic [2:0] ST_BADJ = 3'd3;
  localparam logic [2:0] ST_ILL  = 3'd4;

  typedef enum logic [2:0] {
    KIND_SIMPLE, KIND_DIV, KIND_LOAD, KIND_STB, KIND_STW
  } kind_e;

  typedef enum logic [2:0] {
    MSEL_CLR, MSEL_LOAD, MSEL_FETCH, MSEL_DATA0, MSEL_DATA1
  } msel_e;

  typedef enum logic [1:0] {
    RSEL_CLR, RSEL_S1, RSEL_S2, RSEL_D
  } rsel_e;

  typedef struct packed {
    logic       latch_in;
    logic       clr_step;
    msel_e      mem_sel;
    logic       mem_we;
    logic [1:0] fetch_idx;
    logic       cap_ibyte;
    rsel_e      rf_sel;
    logic       cap_a;
    logic       cap_b;
    logic       cap_d;
    logic       exec;
    logic       div_start;
    logic       wb_div;
    logic       cap_lo;
    logic       cap_hi;
    logic       wb_load;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  stopped;
    kind_e kind;
    logic  clr_last;
    logic  div_done;
    logic  out_free;
  } dp_status_t;

endpackage
`default_nettype wire

### src/tcpu_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tcpu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

### src/tcpu_div.sv
// 16-bit unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module tcpu_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             done_o,
  output logic      [15:0] quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] dvs_q, dvs_d;
  logic [16:0] shifted;
  logic [17:0] diff;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, quo_q[15]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 4'd0;
      rem_d  = 16'd0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[17]) begin
        rem_d = diff[15:0];
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = shifted[15:0];
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

### src/tcpu_ctrl.sv
// sequencer of the toy cpu execute unit
`timescale 1ns / 1ps
`default_nettype none
module tcpu_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  input  wire logic                  s_tuser_i,
  input  wire tcpu_pkg::dp_status_t  sts_i,
  output logic                       s_tready_o,
  output tcpu_pkg::ctrl_cmd_t        cmd_o
);

  typedef enum logic [17:0] {
    S_CLR  = 18'h00001,
    S_IDLE = 18'h00002,
    S_LOAD = 18'h00004,
    S_F0   = 18'h00008,
    S_F1   = 18'h00010,
    S_F2   = 18'h00020,
    S_F3   = 18'h00040,
    S_RA   = 18'h00080,
    S_RB   = 18'h00100,
    S_RD   = 18'h00200,
    S_RX   = 18'h00400,
    S_EX   = 18'h00800,
    S_DV   = 18'h01000,
    S_LD1  = 18'h02000,
    S_LD2  = 18'h04000,
    S_LD3  = 18'h08000,
    S_ST2  = 18'h10000,
    S_RESP = 18'h20000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.mem_sel    = tcpu_pkg::MSEL_FETCH;
    cmd_o.rf_sel     = tcpu_pkg::RSEL_D;
    s_tready_o       = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.mem_sel  = tcpu_pkg::MSEL_CLR;
        cmd_o.mem_we   = 1'b1;
        cmd_o.rf_sel   = tcpu_pkg::RSEL_CLR;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.latch_in = 1'b1;
          if (!s_tuser_i) begin
            state_d = S_LOAD;
          end else if (sts_i.stopped) begin
            state_d = S_RESP;
          end else begin
            state_d = S_F0;
          end
        end
      end
      S_LOAD: begin
        cmd_o.mem_sel = tcpu_pkg::MSEL_LOAD;
        cmd_o.mem_we  = 1'b1;
        state_d       = S_RESP;
      end
      S_F0: begin
        cmd_o.fetch_idx = 2'd0;
        state_d         = S_F1;
      end
      S_F1: begin
        cmd_o.fetch_idx = 2'd1;
        cmd_o.cap_ibyte = 1'b1;
        state_d         = S_F2;
      end
      S_F2: begin
        cmd_o.fetch_idx = 2'd2;
        cmd_o.cap_ibyte = 1'b1;
        state_d         = S_F3;
      end
      S_F3: begin
        cmd_o.fetch_idx = 2'd3;
        cmd_o.cap_ibyte = 1'b1;
        state_d         = S_RA;
      end
      S_RA: begin
        // last instruction byte lands while the first operand is looked up
        cmd_o.fetch_idx = 2'd0;
        cmd_o.cap_ibyte = 1'b1;
        cmd_o.rf_sel    = tcpu_pkg::RSEL_S1;
        state_d         = S_RB;
      end
      S_RB: begin
        cmd_o.cap_a  = 1'b1;
        cmd_o.rf_sel = tcpu_pkg::RSEL_S2;
        state_d      = S_RD;
      end
      S_RD: begin
        cmd_o.cap_b  = 1'b1;
        cmd_o.rf_sel = tcpu_pkg::RSEL_D;
        state_d      = S_RX;
      end
      S_RX: begin
        cmd_o.cap_d = 1'b1;
        state_d     = S_EX;
      end
      S_EX: begin
        cmd_o.exec    = 1'b1;
        cmd_o.mem_sel = tcpu_pkg::MSEL_DATA0;
        cmd_o.mem_we  = (sts_i.kind == tcpu_pkg::KIND_STB) ||
                        (sts_i.kind == tcpu_pkg::KIND_STW);
        case (sts_i.kind)
          tcpu_pkg::KIND_DIV: begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DV;
          end
          tcpu_pkg::KIND_LOAD: state_d = S_LD1;
          tcpu_pkg::KIND_STW:  state_d = S_ST2;
          default:             state_d = S_RESP;
        endcase
      end
      S_DV: begin
        if (sts_i.div_done) begin
          cmd_o.wb_div = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_LD1: begin
        cmd_o.cap_lo  = 1'b1;
        cmd_o.mem_sel = tcpu_pkg::MSEL_DATA1;
        state_d       = S_LD2;
      end
      S_LD2: begin
        cmd_o.cap_hi = 1'b1;
        state_d      = S_LD3;
      end
      S_LD3: begin
        cmd_o.wb_load = 1'b1;
        state_d       = S_RESP;
      end
      S_ST2: begin
        cmd_o.mem_sel = tcpu_pkg::MSEL_DATA1;
        cmd_o.mem_we  = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### src/tcpu_dp.sv
// datapath: memories, registers, alu, divider and result register
`timescale 1ns / 1ps
`default_nettype none
module tcpu_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tcpu_pkg::ctrl_cmd_t                 cmd_i,
  input  wire logic [tcpu_pkg::S_TDATA_W-1:0]      s_tdata_i,
  input  wire logic                                m_tready_i,
  output tcpu_pkg::dp_status_t                     sts_o,
  output logic                                     m_tvalid_o,
  output logic      [tcpu_pkg::M_TDATA_W-1:0]      m_tdata_o
);

  localparam int unsigned AW = tcpu_pkg::ADDR_W;

  // input transaction fields
  logic [15:0] load_addr_q;
  logic [7:0]  load_byte_q;
  logic [15:0] in_value_q;

  // architectural state
  logic [15:0] pc_q;
  logic        z_q, c_q, n_q;
  logic [2:0]  code_q;
  logic        ov_q;
  logic [15:0] oval_q;

  // instruction and operands
  logic [7:0]  ib_q [4];
  logic [15:0] a_q, rb_q, dv_q;
  logic [7:0]  lo_q, hi_q;
  logic [AW-1:0] clr_cnt_q;

  logic                          m_valid_q;
  logic [tcpu_pkg::M_TDATA_W-1:0] m_data_q;

  // memories
  logic                       mem_we;
  logic [AW-1:0]              mem_addr;
  logic [7:0]                 mem_wdata, mem_rdata;
  logic                       rf_we;
  logic [tcpu_pkg::RF_AW-1:0] rf_addr;
  logic [15:0]                rf_wdata, rf_rdata;

  // decode
  logic [4:0]  op, dst, src1;
  logic        imm;
  logic [15:0] raw, neg_raw, imm_val, b;
  logic [13:0] neg_mag;

  // execute
  logic [15:0] npc, fetch_pc, ex_res;
  logic        ex_wr_rf, ex_wr_flags, ex_halt, ex_out;
  logic [2:0]  ex_code;
  logic        ex_z, ex_c, ex_n;
  logic        take;
  tcpu_pkg::kind_e kind;
  logic [17:0] add_r, sub_r, mul_r, div_r;
  logic        a_pos, b_pos;
  logic [15:0] a_neg, b_neg;
  logic [7:0]  ma, mb;
  logic [15:0] mul_p;
  logic [15:0] logic_r;
  logic [3:0]  sh_k;
  logic [16:0] a_ext;
  logic [15:0] sh_r;
  logic        sh_c;
  logic [16:0] addr_sum;
  logic [17:0] addr_fix;
  logic [15:0] ad0, ad1, base;
  logic [15:0] ld_val;
  logic [15:0] div_a, div_b, quot;
  logic        div_done, div_neg;

  function automatic logic above_max(input logic [17:0] r);
    return !r[17] && (r[16:15] != 2'b00);
  endfunction

  function automatic logic below_min(input logic [17:0] r);
    return r[17] && (r[16:15] != 2'b11);
  endfunction

  // ------------------------------------------------------------ decode
  assign op      = ib_q[0][7:3];
  assign dst     = {ib_q[0][2:0], ib_q[1][7:6]};
  assign src1    = ib_q[1][5:1];
  assign imm     = ib_q[1][0];
  assign raw     = {ib_q[2], ib_q[3]};
  assign neg_raw = 16'd0 - raw;
  assign neg_mag = neg_raw[13:0];
  // negative immediates keep a 14-bit magnitude
  assign imm_val = raw[15] ? (16'd0 - {2'b00, neg_mag}) : raw;
  assign b       = imm ? imm_val : rb_q;

  // ------------------------------------------------------------ alu
  assign add_r = {{2{a_q[15]}}, a_q} + {{2{b[15]}}, b};
  assign sub_r = {{2{a_q[15]}}, a_q} - {{2{b[15]}}, b};

  // 8-bit sign-magnitude multiply
  assign a_pos = !a_q[15] && (a_q != 16'd0);
  assign b_pos = !b[15] && (b != 16'd0);
  assign a_neg = 16'd0 - a_q;
  assign b_neg = 16'd0 - b;
  assign ma    = a_pos ? a_q[7:0] : a_neg[7:0];
  assign mb    = b_pos ? b[7:0] : b_neg[7:0];
  assign mul_p = {8'd0, ma} * {8'd0, mb};
  assign mul_r = (a_pos != b_pos) ? (18'd0 - {2'b00, mul_p}) : {2'b00, mul_p};

  // shift by a signed count
  assign a_ext = {a_q[15], a_q};
  always_comb begin
    sh_k = 4'd0;
    sh_r = 16'd0;
    sh_c = 1'b0;
    if ($signed(b) > 16'sd15 || $signed(b) < -16'sd15) begin
      sh_c = b[15] ? a_q[15] : a_q[0];
    end else if (b[15]) begin
      sh_k = b_neg[3:0];
      sh_r = 16'($signed(a_q) >>> sh_k);
      sh_c = a_q[4'(sh_k - 4'd1)];
    end else begin
      sh_k = b[3:0];
      sh_r = a_q << sh_k;
      sh_c = a_ext[5'(5'd16 - {1'b0, sh_k})];
    end
  end

  // data address, floor modulo 65535
  assign base     = (kind == tcpu_pkg::KIND_STB || kind == tcpu_pkg::KIND_STW) ? dv_q : a_q;
  assign addr_sum = {base[15], base} + {b[15], b};
  assign addr_fix = {addr_sum[16], addr_sum} + 18'd65535;
  always_comb begin
    if (!addr_sum[16]) begin
      ad0 = addr_sum[15:0];
    end else if (addr_fix[17]) begin
      // only the lowest sum needs two corrections
      ad0 = 16'd65534;
    end else begin
      ad0 = addr_fix[15:0];
    end
  end
  assign ad1    = (ad0 == 16'd65534) ? 16'd0 : ad0 + 16'd1;
  assign ld_val = (op == tcpu_pkg::OP_LDW) ? {hi_q, lo_q} : {8'd0, lo_q};

  // divide on magnitudes, sign applied afterwards
  assign div_a   = a_q[15] ? a_neg : a_q;
  assign div_b   = b[15] ? b_neg : b;
  assign div_neg = a_q[15] ^ b[15];
  assign div_r   = div_neg ? (18'd0 - {2'b00, quot}) : {2'b00, quot};

  tcpu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // ------------------------------------------------------------ execute
  always_comb begin
    npc         = pc_q + 16'd4;
    ex_res      = 16'd0;
    ex_wr_rf    = 1'b0;
    ex_wr_flags = 1'b0;
    ex_halt     = 1'b0;
    ex_code     = tcpu_pkg::ST_RUN;
    ex_out      = 1'b0;
    ex_z        = z_q;
    ex_c        = c_q;
    ex_n        = n_q;
    take        = 1'b0;
    kind        = tcpu_pkg::KIND_SIMPLE;
    logic_r     = 16'd0;
    case (op)
      tcpu_pkg::OP_ADD: begin
        ex_res = add_r[15:0]; ex_wr_rf = 1'b1; ex_wr_flags = 1'b1;
        ex_z = add_r == 18'd0; ex_c = above_max(add_r);
        ex_n = add_r[17] | above_max(add_r);
      end
      tcpu_pkg::OP_SUB: begin
        ex_res = sub_r[15:0]; ex_wr_rf = 1'b1; ex_wr_flags = 1'b1;
        ex_z = sub_r == 18'd0; ex_c = below_min(sub_r);
        ex_n = sub_r[17] | above_max(sub_r);
      end
      tcpu_pkg::OP_MUL: begin
        ex_res = mul_r[15:0]; ex_wr_rf = 1'b1; ex_wr_flags = 1'b1;
        ex_z = mul_r == 18'd0; ex_c = below_min(mul_r) | above_max(mul_r);
        ex_n = mul_r[17] | above_max(mul_r);
      end
      tcpu_pkg::OP_DIV: begin
        if (b == 16'd0) begin
          ex_halt = 1'b1; ex_code = tcpu_pkg::ST_DIVZ;
        end else begin
          kind = tcpu_pkg::KIND_DIV;
        end
      end
      tcpu_pkg::OP_AND, tcpu_pkg::OP_OR, tcpu_pkg::OP_XOR: begin
        if (op == tcpu_pkg::OP_AND) begin
          logic_r = a_q & b;
        end else if (op == tcpu_pkg::OP_OR) begin
          logic_r = a_q | b;
        end else begin
          logic_r = a_q ^ b;
        end
        ex_res = logic_r; ex_wr_rf = 1'b1; ex_wr_flags = 1'b1;
        ex_z = logic_r == 16'd0; ex_c = 1'b0; ex_n = logic_r[15];
      end
      tcpu_pkg::OP_SHL: begin
        ex_res = sh_r; ex_wr_rf = 1'b1; ex_wr_flags = 1'b1;
        ex_z = sh_r == 16'd0; ex_c = sh_c; ex_n = sh_r[15];
      end
      tcpu_pkg::OP_LDB, tcpu_pkg::OP_LDW: kind = tcpu_pkg::KIND_LOAD;
      tcpu_pkg::OP_STB, tcpu_pkg::OP_STW: begin
        kind = (op == tcpu_pkg::OP_STW) ? tcpu_pkg::KIND_STW : tcpu_pkg::KIND_STB;
        ex_wr_flags = 1'b1;
        // a 16-bit signed sum never exceeds 65535, so no carry out
        ex_z = a_q == 16'd0; ex_c = 1'b0;
        ex_n = (op == tcpu_pkg::OP_STW) && a_q[15];
      end
      tcpu_pkg::OP_JMP, tcpu_pkg::OP_JZS, tcpu_pkg::OP_JZC, tcpu_pkg::OP_JCS,
      tcpu_pkg::OP_JCC, tcpu_pkg::OP_JNS, tcpu_pkg::OP_JNC: begin
        if (b[1:0] != 2'b00) begin
          ex_halt = 1'b1; ex_code = tcpu_pkg::ST_BADJ;
        end else begin
          case (op)
            tcpu_pkg::OP_JZS: take = z_q;
            tcpu_pkg::OP_JZC: take = !z_q;
            tcpu_pkg::OP_JCS: take = c_q;
            tcpu_pkg::OP_JCC: take = !c_q;
            tcpu_pkg::OP_JNS: take = n_q;
            tcpu_pkg::OP_JNC: take = !n_q;
            default:          take = 1'b1;
          endcase
          if (take) begin
            npc = b;
          end
        end
      end
      tcpu_pkg::OP_IN: begin
        ex_res = in_value_q; ex_wr_rf = 1'b1; ex_wr_flags = 1'b1;
        ex_z = in_value_q == 16'd0; ex_c = 1'b0; ex_n = in_value_q[15];
      end
      tcpu_pkg::OP_OUT: begin
        ex_out = 1'b1; ex_wr_flags = 1'b1;
        ex_z = dv_q == 16'd0; ex_c = 1'b0; ex_n = dv_q[15];
      end
      tcpu_pkg::OP_HLT: begin
        ex_halt = 1'b1; ex_code = tcpu_pkg::ST_HALT;
      end
      default: begin
        ex_halt = 1'b1; ex_code = tcpu_pkg::ST_ILL;
      end
    endcase
  end

  // ------------------------------------------------------------ memories
  assign fetch_pc = pc_q + {14'd0, cmd_i.fetch_idx};

  always_comb begin
    case (cmd_i.mem_sel)
      tcpu_pkg::MSEL_CLR: begin
        mem_addr = clr_cnt_q; mem_wdata = 8'd0;
      end
      tcpu_pkg::MSEL_LOAD: begin
        mem_addr = load_addr_q[AW-1:0]; mem_wdata = load_byte_q;
      end
      tcpu_pkg::MSEL_DATA0: begin
        mem_addr = ad0[AW-1:0]; mem_wdata = a_q[7:0];
      end
      tcpu_pkg::MSEL_DATA1: begin
        mem_addr = ad1[AW-1:0]; mem_wdata = a_q[15:8];
      end
      default: begin
        mem_addr = fetch_pc[AW-1:0]; mem_wdata = 8'd0;
      end
    endcase
  end
  assign mem_we = cmd_i.mem_we;

  tcpu_ram #(
    .WIDTH (8),
    .DEPTH (tcpu_pkg::MEM_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    case (cmd_i.rf_sel)
      tcpu_pkg::RSEL_CLR: rf_addr = clr_cnt_q[tcpu_pkg::RF_AW-1:0];
      tcpu_pkg::RSEL_S1:  rf_addr = src1;
      tcpu_pkg::RSEL_S2:  rf_addr = raw[tcpu_pkg::RF_AW-1:0];
      default:            rf_addr = dst;
    endcase
    if (cmd_i.wb_div) begin
      rf_wdata = div_r[15:0];
    end else if (cmd_i.wb_load) begin
      rf_wdata = ld_val;
    end else if (cmd_i.exec) begin
      rf_wdata = ex_res;
    end else begin
      rf_wdata = 16'd0;
    end
  end
  // the clearing pass covers the register file during its first entries
  assign rf_we = (cmd_i.clr_step && (clr_cnt_q[AW-1:tcpu_pkg::RF_AW] == '0)) ||
                 (cmd_i.exec && ex_wr_rf && !ex_halt) || cmd_i.wb_div || cmd_i.wb_load;

  tcpu_ram #(
    .WIDTH (16),
    .DEPTH (tcpu_pkg::RF_DEPTH)
  ) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .addr_i  (rf_addr),
    .wdata_i (rf_wdata),
    .rdata_o (rf_rdata)
  );

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= 16'd0;
      z_q       <= 1'b0;
      c_q       <= 1'b0;
      n_q       <= 1'b0;
      code_q    <= tcpu_pkg::ST_RUN;
      ov_q      <= 1'b0;
      clr_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.latch_in) begin
        ov_q <= 1'b0;
      end
      if (cmd_i.exec) begin
        if (ex_halt) begin
          code_q <= ex_code;
        end else begin
          pc_q <= npc;
          if (ex_wr_flags) begin
            z_q <= ex_z;
            c_q <= ex_c;
            n_q <= ex_n;
          end
          ov_q <= ex_out;
        end
      end
      if (cmd_i.wb_div) begin
        z_q <= div_r == 18'd0;
        c_q <= above_max(div_r) | below_min(div_r);
        n_q <= div_r[17] | above_max(div_r);
      end
      if (cmd_i.wb_load) begin
        z_q <= ld_val == 16'd0;
        c_q <= 1'b0;
        n_q <= ld_val[15];
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      load_addr_q <= s_tdata_i[15:0];
      load_byte_q <= s_tdata_i[23:16];
      in_value_q  <= s_tdata_i[39:24];
    end
    if (cmd_i.cap_ibyte) begin
      ib_q[2'(cmd_i.fetch_idx - 2'd1)] <= mem_rdata;
    end
    if (cmd_i.cap_a) begin
      a_q <= rf_rdata;
    end
    if (cmd_i.cap_b) begin
      rb_q <= rf_rdata;
    end
    if (cmd_i.cap_d) begin
      dv_q <= rf_rdata;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= mem_rdata;
    end
    if (cmd_i.cap_hi) begin
      hi_q <= mem_rdata;
    end
    if (cmd_i.exec && ex_out && !ex_halt) begin
      oval_q <= dv_q;
    end
    if (cmd_i.out_load) begin
      m_data_q <= {1'b0, code_q, (ov_q ? oval_q : 16'd0), ov_q, n_q, c_q, z_q, pc_q};
    end
  end

  assign sts_o.stopped  = code_q != tcpu_pkg::ST_RUN;
  assign sts_o.kind     = kind;
  assign sts_o.clr_last = clr_cnt_q == AW'(tcpu_pkg::MEM_BYTES - 1);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !m_valid_q || m_tready_i;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule
`default_nettype wire

### src/toy_cpu_execute_unit.sv
// top level of the toy cpu execute unit
// a 16-bit processor driven one transaction at a time on a stream port.
// input: s_axis_tuser selects the command (0 writes a program byte at
// load_addr, 1 executes the instruction at pc, with in_value for IN).
// output: every input transaction gives exactly one result transaction
// carrying next pc, the flags, the OUT value and the run status.
// cycles per transaction: a byte write takes 3, a step of a stopped machine 2,
// an instruction 11 to 14 (loads longest), a division 17 more for the
// one-bit-per-cycle divider; the four single-port fetch reads plus the
// register file reads through one port set this figure. only one instruction
// is in flight; the next is taken once the result has moved to the output
// register, so a pending result does not block the input.
// reset: byte memory and registers are cleared by a pass of MEM_BYTES
// cycles (65536), during which s_axis_tready stays low.
// a stalled receiver holds the result in the output register; the block
// finishes its current transaction and waits before taking the next.
`timescale 1ns / 1ps
`default_nettype none
`include "toy_cpu_execute_unit_assert.svh"
module toy_cpu_execute_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // load_addr[15:0], load_byte[23:16], in_value[39:24]
  input  wire logic [39:0] s_axis_tdata,
  // cmd
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // next_pc[15:0], flag_zero[16], flag_carry[17], flag_negative[18],
  // out_valid[19], out_value[35:20], status[38:36], zero pad[39]
  output logic      [39:0] m_axis_tdata
);

  tcpu_pkg::ctrl_cmd_t  cmd;
  tcpu_pkg::dp_status_t sts;

  tcpu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .sts_i      (sts),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  tcpu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .s_tdata_i  (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .sts_o      (sts),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

  `TCPU_ASSERT_IMPL(a_out_free, cmd.out_load, sts.out_free, "result overwrites pending transaction")
  `TCPU_ASSERT_IMPL(a_clr_busy, cmd.clr_step, !s_axis_tready, "input taken during clearing pass")
  `TCPU_ASSERT_IMPL(a_div_wb, sts.div_done, cmd.wb_div, "quotient not written back")
  `TCPU_ASSERT_NEXT(a_one_item, cmd.latch_in, !s_axis_tready, "second transaction taken while busy")

endmodule
`default_nettype wire

### tb/sv/toy_cpu_execute_unit_tb.sv
// self-checking testbench for the toy cpu execute unit
`timescale 1ns / 1ps
module toy_cpu_execute_unit_tb;

  typedef struct packed {
    logic [2:0]  st;
    logic [15:0] oval;
    logic        ov;
    logic        nf;
    logic        cf;
    logic        zf;
    logic [15:0] pc;
  } cpu_res_t;

  typedef struct {
    logic [4:0]  op;
    logic [4:0]  dst;
    logic [4:0]  src1;
    logic        imm;
    logic [15:0] raw;
    logic [15:0] inval;
    logic [39:0] res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  toy_cpu_execute_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // shadow machine state
  logic [15:0] cpu_regs [32];
  logic [7:0]  cpu_mem [65536];
  logic [15:0] cpu_pc;
  logic        cpu_z, cpu_c, cpu_n, cpu_stopped;
  logic [2:0]  cpu_stop_code;

  cpu_res_t    pending_res_q [$];
  logic [39:0] typed_res_q [$];
  logic        typed_chk_q [$];
  int          fail_cnt = 0;
  bit          calm = 1'b0;
  int          quiet_cycles = 0;

  function automatic int sx16(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic int operand_b(logic imm, logic [15:0] raw);
    int unsigned mag;
    if (!imm) return sx16(cpu_regs[raw[4:0]]);
    if (!raw[15]) return int'(raw);
    mag = (32'd0 - {16'd0, raw}) & 32'h3FFF;
    return -int'(mag);
  endfunction

  function automatic int unsigned wrap_addr(int s);
    int m;
    m = s % 65535;
    if (m < 0) m += 65535;
    return m;
  endfunction

  function automatic void arith_wb(int r, bit cy, logic [4:0] d);
    cpu_z = (r == 0);
    cpu_c = cy;
    cpu_n = (r < 0) || (r > 32767);
    cpu_regs[d] = r[15:0];
  endfunction

  function automatic void stop_with(logic [2:0] code);
    cpu_stopped = 1'b1;
    cpu_stop_code = code;
  endfunction

  // advance the shadow machine by one transaction and return its result
  function automatic cpu_res_t cpu_step(logic cmd, logic [15:0] la, logic [7:0] lb,
                                        logic [15:0] iv);
    cpu_res_t    res;
    logic [7:0]  b0, b1, b2, b3;
    logic [4:0]  op, d, s1;
    logic [15:0] raw, npc, v;
    int          a, b, r, s, ma, mb;
    int unsigned ua, ad, k, sh;
    bit          cy, take;
    res = '0;
    if (!cmd) begin
      cpu_mem[la] = lb;
    end else if (!cpu_stopped) begin
      b0 = cpu_mem[cpu_pc];
      b1 = cpu_mem[16'(cpu_pc + 1)];
      b2 = cpu_mem[16'(cpu_pc + 2)];
      b3 = cpu_mem[16'(cpu_pc + 3)];
      op = b0[7:3];
      d = {b0[2:0], b1[7:6]};
      s1 = b1[5:1];
      raw = {b2, b3};
      a = sx16(cpu_regs[s1]);
      ua = a;
      b = operand_b(b1[0], raw);
      npc = cpu_pc + 16'd4;
      case (op)
        tcpu_pkg::OP_ADD: begin r = a + b; arith_wb(r, r > 32767, d); end
        tcpu_pkg::OP_SUB: begin r = a - b; arith_wb(r, r < -32768, d); end
        tcpu_pkg::OP_MUL: begin
          ma = (a > 0) ? (a & 255) : ((-a) & 255);
          mb = (b > 0) ? (b & 255) : ((-b) & 255);
          r = ma * mb;
          if ((b > 0) != (a > 0)) r = -r;
          arith_wb(r, r < -32768 || r > 32767, d);
        end
        tcpu_pkg::OP_DIV: begin
          if (b == 0) begin
            stop_with(tcpu_pkg::ST_DIVZ);
            npc = cpu_pc;
          end else begin
            r = a / b;
            arith_wb(r, r < -32768 || r > 32767, d);
          end
        end
        tcpu_pkg::OP_AND, tcpu_pkg::OP_OR, tcpu_pkg::OP_XOR: begin
          r = (op == tcpu_pkg::OP_AND) ? (a & b) :
              (op == tcpu_pkg::OP_OR) ? (a | b) : (a ^ b);
          cpu_z = (r == 0); cpu_c = 1'b0; cpu_n = (r < 0);
          cpu_regs[d] = r[15:0];
        end
        tcpu_pkg::OP_SHL: begin
          if (b > 15 || b < -15) begin
            cy = (b < 0) ? (a < 0) : ua[0];
            sh = 0;
          end else if (b < 0) begin
            k = -b;
            cy = (ua >> (k - 1)) & 1;
            sh = ua >> k;
          end else begin
            k = b;
            cy = (ua >> (16 - k)) & 1;
            sh = ua << k;
          end
          cpu_regs[d] = sh[15:0];
          cpu_z = (sh[15:0] == 0); cpu_c = cy; cpu_n = sh[15];
        end
        tcpu_pkg::OP_LDB, tcpu_pkg::OP_LDW: begin
          s = a + b;
          ad = wrap_addr(s);
          v = {8'd0, cpu_mem[ad[15:0]]};
          if (op == tcpu_pkg::OP_LDW) v[15:8] = cpu_mem[16'(wrap_addr(ad + 1))];
          cpu_regs[d] = v;
          cpu_z = (v == 0); cpu_c = (s > 65535); cpu_n = v[15];
        end
        tcpu_pkg::OP_STB, tcpu_pkg::OP_STW: begin
          s = sx16(cpu_regs[d]) + b;
          ad = wrap_addr(s);
          cpu_mem[ad[15:0]] = ua[7:0];
          if (op == tcpu_pkg::OP_STW) cpu_mem[16'(wrap_addr(ad + 1))] = ua[15:8];
          cpu_z = (a == 0); cpu_c = (s > 65535);
          cpu_n = (op == tcpu_pkg::OP_STW) && (a < 0);
        end
        tcpu_pkg::OP_JMP, tcpu_pkg::OP_JZS, tcpu_pkg::OP_JZC, tcpu_pkg::OP_JCS,
        tcpu_pkg::OP_JCC, tcpu_pkg::OP_JNS, tcpu_pkg::OP_JNC: begin
          if (b[1:0] != 2'b00) begin
            stop_with(tcpu_pkg::ST_BADJ);
            npc = cpu_pc;
          end else begin
            case (op)
              tcpu_pkg::OP_JZS: take = cpu_z;
              tcpu_pkg::OP_JZC: take = !cpu_z;
              tcpu_pkg::OP_JCS: take = cpu_c;
              tcpu_pkg::OP_JCC: take = !cpu_c;
              tcpu_pkg::OP_JNS: take = cpu_n;
              tcpu_pkg::OP_JNC: take = !cpu_n;
              default:          take = 1'b1;
            endcase
            if (take) npc = b[15:0];
          end
        end
        tcpu_pkg::OP_IN: begin
          cpu_regs[d] = iv;
          cpu_z = (iv == 0); cpu_c = 1'b0; cpu_n = iv[15];
        end
        tcpu_pkg::OP_OUT: begin
          v = cpu_regs[d];
          res.ov = 1'b1;
          res.oval = v;
          cpu_z = (v == 0); cpu_c = 1'b0; cpu_n = v[15];
        end
        tcpu_pkg::OP_HLT: begin stop_with(tcpu_pkg::ST_HALT); npc = cpu_pc; end
        default: begin stop_with(tcpu_pkg::ST_ILL); npc = cpu_pc; end
      endcase
      cpu_pc = npc;
    end
    res.pc = cpu_pc;
    res.zf = cpu_z;
    res.cf = cpu_c;
    res.nf = cpu_n;
    res.st = cpu_stopped ? cpu_stop_code : tcpu_pkg::ST_RUN;
    return res;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // one transaction on the input side, with the odd idle burst
  task automatic send_item(logic cmd, logic [15:0] la, logic [7:0] lb, logic [15:0] iv,
                           bit chk, logic [39:0] typed);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {iv, lb, la};
    pending_res_q.push_back(cpu_step(cmd, la, lb, iv));
    typed_chk_q.push_back(chk);
    typed_res_q.push_back(typed);
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic send_instr(logic [4:0] op, logic [4:0] d, logic [4:0] s1, logic imm,
                            logic [15:0] raw, logic [15:0] iv, bit chk, logic [39:0] typed);
    logic [15:0] at;
    at = cpu_pc;
    send_item(1'b0, at, {op, d[4:2]}, 16'($urandom), 1'b0, '0);
    send_item(1'b0, 16'(at + 1), {d[1:0], s1, imm}, 16'($urandom), 1'b0, '0);
    send_item(1'b0, 16'(at + 2), raw[15:8], 16'($urandom), 1'b0, '0);
    send_item(1'b0, 16'(at + 3), raw[7:0], 16'($urandom), 1'b0, '0);
    send_item(1'b1, 16'($urandom), 8'($urandom), iv, chk, typed);
  endtask

  // receiver back-pressure
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cpu_res_t got, want;
    logic [39:0] typed;
    bit chk;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[38:0];
      if (pending_res_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata);
        fail_cnt++;
      end else begin
        want = pending_res_q.pop_front();
        chk = typed_chk_q.pop_front();
        typed = typed_res_q.pop_front();
        if (got.pc != want.pc) begin
          $display("%0t next_pc exp %h got %h", $time, want.pc, got.pc); fail_cnt++;
        end
        if (got.zf != want.zf) begin
          $display("%0t flag_zero exp %b got %b", $time, want.zf, got.zf); fail_cnt++;
        end
        if (got.cf != want.cf) begin
          $display("%0t flag_carry exp %b got %b", $time, want.cf, got.cf); fail_cnt++;
        end
        if (got.nf != want.nf) begin
          $display("%0t flag_negative exp %b got %b", $time, want.nf, got.nf); fail_cnt++;
        end
        if (got.ov != want.ov) begin
          $display("%0t out_valid exp %b got %b", $time, want.ov, got.ov); fail_cnt++;
        end
        if (got.oval != want.oval) begin
          $display("%0t out_value exp %h got %h", $time, want.oval, got.oval); fail_cnt++;
        end
        if (got.st != want.st) begin
          $display("%0t status exp %0d got %0d", $time, want.st, got.st); fail_cnt++;
        end
        if (chk && m_axis_tdata != typed) begin
          $display("%0t directed result exp %h got %h", $time, typed, m_axis_tdata);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all; allows for the clearing pass
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 200000) begin
        $display("toy_cpu_execute_unit_tb: FAIL");
        $finish;
      end
    end
  end

  dir_row_t dir_rows [5];
  logic [4:0] safe_ops [20] = '{tcpu_pkg::OP_ADD, tcpu_pkg::OP_SUB, tcpu_pkg::OP_MUL,
    tcpu_pkg::OP_DIV, tcpu_pkg::OP_AND, tcpu_pkg::OP_OR, tcpu_pkg::OP_XOR,
    tcpu_pkg::OP_SHL, tcpu_pkg::OP_LDB, tcpu_pkg::OP_LDW, tcpu_pkg::OP_STB,
    tcpu_pkg::OP_STW, tcpu_pkg::OP_JMP, tcpu_pkg::OP_JZS, tcpu_pkg::OP_JZC,
    tcpu_pkg::OP_JCS, tcpu_pkg::OP_JCC, tcpu_pkg::OP_JNS, tcpu_pkg::OP_JNC,
    tcpu_pkg::OP_IN};
  logic [4:0] bad_ops [10] = '{5'd8, 5'd9, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
    5'd29, 5'd30};
  logic [15:0] edge_vals [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd15,
    16'hFFF1, 16'd16, 16'hC000};

  initial begin
    int          n_items;
    logic [4:0]  op, d, s1;
    logic        imm;
    logic [15:0] raw;
    int          b;
    for (int i = 0; i < 32; i++) cpu_regs[i] = '0;
    for (int i = 0; i < 65536; i++) cpu_mem[i] = '0;
    cpu_pc = '0; cpu_z = 0; cpu_c = 0; cpu_n = 0; cpu_stopped = 0;
    cpu_stop_code = tcpu_pkg::ST_RUN;

    // IN max, ADD overflow, OUT of a negative value, MUL zero magnitude, taken jump
    dir_rows[0] = '{tcpu_pkg::OP_IN,  5'd1,  5'd0, 1'b0, 16'h0000, 16'h7FFF,
                    40'h0000000004};
    dir_rows[1] = '{tcpu_pkg::OP_ADD, 5'd2,  5'd1, 1'b1, 16'h0001, 16'h0000,
                    40'h0000060008};
    dir_rows[2] = '{tcpu_pkg::OP_OUT, 5'd2,  5'd0, 1'b0, 16'h0000, 16'h0000,
                    40'h08000C000C};
    dir_rows[3] = '{tcpu_pkg::OP_MUL, 5'd3,  5'd2, 1'b1, 16'hFFFF, 16'h0000,
                    40'h0000010010};
    dir_rows[4] = '{tcpu_pkg::OP_JZS, 5'd31, 5'd31, 1'b1, 16'h0100, 16'h8000,
                    40'h0000010100};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_instr(dir_rows[i].op, dir_rows[i].dst, dir_rows[i].src1, dir_rows[i].imm,
                 dir_rows[i].raw, dir_rows[i].inval, 1'b1, dir_rows[i].res);

    n_items = 25;
    while (n_items < 1920) begin
      if (n_items > 1600) calm = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        // stray byte writes and broken sequences
        send_item(1'b0, 16'($urandom), 8'($urandom), 16'($urandom), 1'b0, '0);
        n_items++;
      end else begin
        op = safe_ops[$urandom_range(0, 19)];
        if ($urandom_range(0, 9) == 0) op = tcpu_pkg::OP_OUT;
        d = $urandom; s1 = $urandom; imm = $urandom;
        raw = ($urandom_range(0, 3) == 0) ? edge_vals[$urandom_range(0, 7)] : 16'($urandom);
        if (op == tcpu_pkg::OP_SHL && imm && $urandom_range(0, 1))
          raw = 16'($urandom_range(0, 33) - 17);
        b = operand_b(imm, raw);
        // keep the machine running: no zero divisor or misaligned target here
        if (op == tcpu_pkg::OP_DIV && b == 0) begin imm = 1'b1; raw = 16'd3; end
        if (op >= tcpu_pkg::OP_JMP && op <= tcpu_pkg::OP_JNC && b[1:0] != 2'b00) begin
          imm = 1'b1;
          raw = raw & 16'h7FFC;
        end
        send_instr(op, d, s1, imm, raw, 16'($urandom), 1'b0, '0);
        n_items += 5;
      end
    end

    // one stopping instruction, then a stopped machine that still takes byte writes
    case ($urandom_range(0, 3))
      0: send_instr(tcpu_pkg::OP_HLT, 5'd0, 5'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      1: send_instr(tcpu_pkg::OP_DIV, 5'd4, 5'd5, 1'b1, 16'h0000, 16'h0000, 1'b0, '0);
      2: send_instr(tcpu_pkg::OP_JMP, 5'd0, 5'd0, 1'b1, 16'h0002, 16'h0000, 1'b0, '0);
      default: send_instr(bad_ops[$urandom_range(0, 9)], 5'd7, 5'd3, 1'b0, 16'h1234,
                          16'h0000, 1'b0, '0);
    endcase
    send_item(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0, '0);
    send_item(1'b0, 16'hFFFF, 8'hFF, 16'h8000, 1'b0, '0);
    send_item(1'b1, 16'h0000, 8'h00, 16'h0000, 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    for (int w = 0; w < 100000 && pending_res_q.size() != 0; w++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && pending_res_q.size() == 0) begin
      $display("toy_cpu_execute_unit_tb: PASS");
    end else begin
      $display("toy_cpu_execute_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
